FILE: rtl/sfd_pkg.sv
// Package: phase codes, status codes, register indexes and shared types of the deframer.
`default_nettype none
package sfd_pkg;

    localparam logic [2:0] PH_HUNT   = 3'd0;
    localparam logic [2:0] PH_LEN    = 3'd1;
    localparam logic [2:0] PH_CMD_HI = 3'd2;
    localparam logic [2:0] PH_CMD_LO = 3'd3;
    localparam logic [2:0] PH_DATA   = 3'd4;
    localparam logic [2:0] PH_CHECK  = 3'd5;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_BADSUM  = 2'd1;
    localparam logic [1:0] ST_TOOLONG = 2'd2;

    localparam logic CFG_START_BYTE  = 1'b0;
    localparam logic CFG_MAX_PAYLOAD = 1'b1;

    localparam logic [7:0] START_BYTE_RST  = 8'd254;
    localparam logic [7:0] MAX_PAYLOAD_RST = 8'd250;

    typedef struct packed {
        logic [2:0]  phase;
        logic [7:0]  declared_length;
        logic [7:0]  bytes_seen;
        logic [15:0] command_word;
        logic [7:0]  running_check;
    } t_state;

    typedef struct packed {
        logic [7:0]  payload_byte;
        logic [15:0] frame_command;
        logic [7:0]  frame_length;
        logic        frame_end;
        logic [1:0]  end_status;
    } t_result;

endpackage
`default_nettype wire

FILE: rtl/sfd_step.sv
// Next-state and result logic for one received byte.
`default_nettype none
module sfd_step
    import sfd_pkg::*;
(
    input  wire t_state     i_state,
    input  wire logic [7:0] i_byte,
    input  wire logic [7:0] i_start_byte,
    input  wire logic [7:0] i_max_payload,
    output t_state          o_state,
    output logic            o_emit,
    output t_result         o_result
);

    logic [7:0] seen_inc;
    logic       is_end;
    logic [1:0] status;
    logic [7:0] data;

    always_comb begin
        o_state  = i_state;
        o_emit   = 1'b0;
        is_end   = 1'b0;
        status   = ST_OK;
        data     = 8'd0;
        seen_inc = i_state.bytes_seen + 8'd1;

        case (i_state.phase)
            PH_LEN: begin
                o_state.declared_length = i_byte;
                o_state.running_check   = i_byte;
                if (i_byte > i_max_payload) begin
                    o_emit        = 1'b1;
                    is_end        = 1'b1;
                    status        = ST_TOOLONG;
                    o_state.phase = PH_HUNT;
                end else begin
                    o_state.phase = PH_CMD_HI;
                end
            end
            PH_CMD_HI: begin
                o_state.command_word  = {i_byte, 8'd0};
                o_state.running_check = i_state.running_check ^ i_byte;
                o_state.phase         = PH_CMD_LO;
            end
            PH_CMD_LO: begin
                o_state.command_word  = {i_state.command_word[15:8], i_byte};
                o_state.running_check = i_state.running_check ^ i_byte;
                o_state.bytes_seen    = 8'd0;
                o_state.phase = (i_state.declared_length == 8'd0) ? PH_CHECK : PH_DATA;
            end
            PH_DATA: begin
                o_state.running_check = i_state.running_check ^ i_byte;
                o_state.bytes_seen    = seen_inc;
                if (seen_inc >= i_state.declared_length) begin
                    o_state.phase = PH_CHECK;
                end
                o_emit = 1'b1;
                data   = i_byte;
            end
            PH_CHECK: begin
                o_emit        = 1'b1;
                is_end        = 1'b1;
                status        = (i_byte == i_state.running_check) ? ST_OK : ST_BADSUM;
                o_state.phase = PH_HUNT;
            end
            default: begin
                // hunt; unused codes fall back here too
                if (i_byte == i_start_byte) begin
                    o_state.declared_length = 8'd0;
                    o_state.bytes_seen      = 8'd0;
                    o_state.command_word    = 16'd0;
                    o_state.running_check   = 8'd0;
                    o_state.phase           = PH_LEN;
                end else begin
                    o_state.phase = PH_HUNT;
                end
            end
        endcase

        o_result.payload_byte  = data;
        o_result.frame_command = o_state.command_word;
        o_result.frame_length  = o_state.declared_length;
        o_result.frame_end     = is_end;
        o_result.end_status    = status;
    end

endmodule
`default_nettype wire

FILE: rtl/sof_frame_xor_fcs_deframer_core.sv
// Top level: start-of-frame deframer with XOR check byte.
// Input channel: one received byte per transaction (i_in_valid / o_in_ready).
// Output channel: payload bytes as they arrive, and one closing transaction per
// frame with o_frame_end set and o_end_status ok, checksum error or too long.
// Configuration channel: index 0 sets the start byte, index 1 the largest
// payload length; o_cfg_ready is always high. Write only while the block is idle.
// The byte is held in an input register; the frame logic then updates
// the frame state and loads the result register, which drives the
// outputs. A result is visible once it is in the result register.
// One byte is accepted every cycle unless stalled; the frame step is combinational.
// Stall: while the result register is full and not taken, the input register
// holds and o_in_ready follows it; no transaction is dropped.
// Reset: hunting for the start byte, both channels empty, start byte 254,
// largest payload 250.
`default_nettype none
module sof_frame_xor_fcs_deframer_core
    import sfd_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [7:0]  i_rx_byte,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [7:0]       o_payload_byte,
    output logic [15:0]      o_frame_command,
    output logic [7:0]       o_frame_length,
    output logic             o_frame_end,
    output logic [1:0]       o_end_status,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic        i_cfg_index,
    input  wire logic [7:0]  i_cfg_data
);

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_out_valid;
    t_result    r_result;
    t_state     r_state;
    logic [7:0] r_start_byte;
    logic [7:0] r_max_payload;

    t_state     n_state;
    t_result    n_result;
    logic       n_emit;
    logic       advance;

    sfd_step u_step (
        .i_state       (r_state),
        .i_byte        (r_in_byte),
        .i_start_byte  (r_start_byte),
        .i_max_payload (r_max_payload),
        .o_state       (n_state),
        .o_emit        (n_emit),
        .o_result      (n_result)
    );

    assign advance     = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_in_valid || advance;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_byte  <= START_BYTE_RST;
            r_max_payload <= MAX_PAYLOAD_RST;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == CFG_START_BYTE) begin
                r_start_byte <= i_cfg_data;
            end else begin
                r_max_payload <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_byte <= i_rx_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= '0;
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_state     <= n_state;
            r_out_valid <= n_emit;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && n_emit) begin
            r_result <= n_result;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_payload_byte  = r_result.payload_byte;
    assign o_frame_command = r_result.frame_command;
    assign o_frame_length  = r_result.frame_length;
    assign o_frame_end     = r_result.frame_end;
    assign o_end_status    = r_result.end_status;

endmodule
`default_nettype wire

FILE: bench/sof_frame_xor_fcs_deframer_core_tb.sv
// Testbench for the deframer: framed and broken byte traffic, results checked against a model.
module sof_frame_xor_fcs_deframer_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import sfd_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 8;
    localparam int LONG_STALL   = 300;

    logic        i_clk;
    logic        i_rst_n     = 1'b0;
    logic        i_in_valid  = 1'b0;
    logic [7:0]  i_rx_byte   = 8'h00;
    logic        i_out_ready = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic        i_cfg_index = CFG_START_BYTE;
    logic [7:0]  i_cfg_data  = 8'h00;
    logic        o_in_ready;
    logic        o_out_valid;
    logic [7:0]  o_payload_byte;
    logic [15:0] o_frame_command;
    logic [7:0]  o_frame_length;
    logic        o_frame_end;
    logic [1:0]  o_end_status;
    logic        o_cfg_ready;

    sof_frame_xor_fcs_deframer_core dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_rx_byte       (i_rx_byte),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_payload_byte  (o_payload_byte),
        .o_frame_command (o_frame_command),
        .o_frame_length  (o_frame_length),
        .o_frame_end     (o_frame_end),
        .o_end_status    (o_end_status),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    // Model copy of the frame state and registers
    t_state      rx_state    = '0;
    logic [7:0]  sof_cfg     = START_BYTE_RST;
    logic [7:0]  max_len_cfg = MAX_PAYLOAD_RST;

    logic [7:0]  pending_bytes[$];
    t_result     frames_due[$];

    logic        in_fire    = 1'b0;
    logic        cfg_fire   = 1'b0;
    logic        quiet_tail = 1'b0;
    int          cycle_count    = 0;
    int          fault_count    = 0;
    int          stall_requests = 0;
    int          stall_served   = 0;
    int          stall_left     = 0;
    int          src_gap        = 0;
    int          src_calm_left  = 0;
    bit          src_calm       = 1'b0;
    int          sink_gap       = 0;
    int          sink_calm_left = 0;
    bit          sink_calm      = 1'b0;

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // Advance the frame state by one byte; return 1 when the byte yields a result.
    function automatic bit deframe_byte(input logic [7:0] b, output t_result res);
        bit         emits;
        bit         closing;
        logic [7:0] data;
        logic [1:0] status;
        emits   = 1'b0;
        closing = 1'b0;
        data    = 8'h00;
        status  = ST_OK;
        case (rx_state.phase)
            PH_LEN: begin
                rx_state.declared_length = b;
                rx_state.running_check   = b;
                if (b > max_len_cfg) begin
                    emits          = 1'b1;
                    closing        = 1'b1;
                    status         = ST_TOOLONG;
                    rx_state.phase = PH_HUNT;
                end else begin
                    rx_state.phase = PH_CMD_HI;
                end
            end
            PH_CMD_HI: begin
                rx_state.command_word  = {b, 8'h00};
                rx_state.running_check ^= b;
                rx_state.phase         = PH_CMD_LO;
            end
            PH_CMD_LO: begin
                rx_state.command_word[7:0] = b;
                rx_state.running_check ^= b;
                rx_state.bytes_seen    = 8'h00;
                rx_state.phase = (rx_state.declared_length == 8'h00) ? PH_CHECK : PH_DATA;
            end
            PH_DATA: begin
                rx_state.running_check ^= b;
                rx_state.bytes_seen    = rx_state.bytes_seen + 8'd1;
                if (rx_state.bytes_seen >= rx_state.declared_length)
                    rx_state.phase = PH_CHECK;
                emits = 1'b1;
                data  = b;
            end
            PH_CHECK: begin
                emits          = 1'b1;
                closing        = 1'b1;
                status         = (b == rx_state.running_check) ? ST_OK : ST_BADSUM;
                rx_state.phase = PH_HUNT;
            end
            default: begin
                // hunt; unused phase codes land here too
                if (b == sof_cfg) begin
                    rx_state       = '0;
                    rx_state.phase = PH_LEN;
                end else begin
                    rx_state.phase = PH_HUNT;
                end
            end
        endcase
        res.payload_byte  = data;
        res.frame_command = rx_state.command_word;
        res.frame_length  = rx_state.declared_length;
        res.frame_end     = closing;
        res.end_status    = status;
        return emits;
    endfunction

    function automatic void report_fault(input string what, input t_result want,
                                         input t_result got);
        fault_count++;
        if (fault_count <= 10)
            $display("cycle %0d %s: want byte %02h cmd %04h len %0d end %0b st %0d,",
                     cycle_count, what, want.payload_byte, want.frame_command,
                     want.frame_length, want.frame_end, want.end_status,
                     " got byte %02h cmd %04h len %0d end %0b st %0d",
                     got.payload_byte, got.frame_command, got.frame_length,
                     got.frame_end, got.end_status);
    endfunction

    // Check results, track handshakes and predict at the rising edge.
    always @(posedge i_clk) begin
        t_result want;
        t_result got;
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end else begin
            if (i_rst_n && o_out_valid && i_out_ready) begin
                got = {o_payload_byte, o_frame_command, o_frame_length, o_frame_end,
                       o_end_status};
                if (frames_due.size() == 0) begin
                    report_fault("unexpected result", '0, got);
                end else begin
                    want = frames_due.pop_front();
                    if (got !== want)
                        report_fault("mismatch", want, got);
                end
            end
            in_fire  <= i_rst_n && i_in_valid && o_in_ready;
            cfg_fire <= i_rst_n && i_cfg_valid && o_cfg_ready;
            if (i_rst_n && i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_START_BYTE:  sof_cfg     <= i_cfg_data;
                    CFG_MAX_PAYLOAD: max_len_cfg <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_rst_n && i_in_valid && o_in_ready) begin
                if (deframe_byte(i_rx_byte, want))
                    frames_due.push_back(want);
            end
        end
    end

    // Long receiver hold-off, counted here on request.
    always @(posedge i_clk) begin
        if (stall_served != stall_requests) begin
            stall_served <= stall_requests;
            stall_left   <= LONG_STALL;
        end else if (stall_left != 0) begin
            stall_left <= stall_left - 1;
        end
    end

    // Byte driver: hold each transaction until taken, random gaps between them.
    always @(negedge i_clk) begin
        if (src_calm_left == 0) begin
            src_calm      = ($urandom_range(0, 2) == 0);
            src_calm_left = $urandom_range(20, 80);
        end else begin
            src_calm_left--;
        end
        if (i_rst_n && (!i_in_valid || in_fire)) begin
            if (src_gap != 0) begin
                src_gap--;
                i_in_valid <= 1'b0;
            end else if (pending_bytes.size() != 0) begin
                i_in_valid <= 1'b1;
                i_rx_byte  <= pending_bytes.pop_front();
                if (!quiet_tail && !src_calm && $urandom_range(0, 3) == 0)
                    src_gap = $urandom_range(1, 7);
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Result receiver: random stall bursts plus the long hold-off.
    always @(negedge i_clk) begin
        if (sink_calm_left == 0) begin
            sink_calm      = ($urandom_range(0, 2) == 0);
            sink_calm_left = $urandom_range(20, 80);
        end else begin
            sink_calm_left--;
        end
        if (sink_gap == 0 && !quiet_tail && !sink_calm && $urandom_range(0, 4) == 0)
            sink_gap = $urandom_range(1, 7);
        i_out_ready <= i_rst_n && sink_gap == 0 && stall_left == 0;
        if (sink_gap != 0)
            sink_gap--;
    end

    task automatic add_frame(input logic [7:0] len, input logic [15:0] cmd, input bit bad);
        logic [7:0] sum;
        logic [7:0] b;
        pending_bytes.push_back(sof_cfg);
        pending_bytes.push_back(len);
        pending_bytes.push_back(cmd[15:8]);
        pending_bytes.push_back(cmd[7:0]);
        sum = len ^ cmd[15:8] ^ cmd[7:0];
        repeat (len) begin
            // mix in the start byte as plain data now and then
            b = ($urandom_range(0, 7) == 0) ? sof_cfg : 8'($urandom);
            sum ^= b;
            pending_bytes.push_back(b);
        end
        if (bad)
            sum ^= 8'($urandom_range(1, 255));
        pending_bytes.push_back(sum);
    endtask

    // Mostly well-formed frames, some too long, some cut short, some line noise.
    task automatic add_traffic(input int target);
        int         fed;
        int         kind;
        int         n;
        int         cap;
        logic [7:0] len;
        fed = 0;
        cap = (max_len_cfg < 8'd12) ? max_len_cfg : 12;
        while (fed < target) begin
            kind = $urandom_range(0, 99);
            if (kind < 8) begin
                n = $urandom_range(1, 3);
                repeat (n) pending_bytes.push_back(8'($urandom));
            end else if (kind < 14) begin
                n = $urandom_range(1, 4);
                pending_bytes.push_back(sof_cfg);
                repeat (n) pending_bytes.push_back(8'($urandom));
                fed += n + 1;
            end else if (kind < 22 && max_len_cfg != 8'hFF) begin
                pending_bytes.push_back(sof_cfg);
                pending_bytes.push_back(8'($urandom_range(max_len_cfg + 1, 255)));
                fed += 2;
            end else begin
                if ($urandom_range(0, 9) == 0)
                    len = 8'($urandom_range(0, max_len_cfg));
                else
                    len = 8'($urandom_range(0, cap));
                add_frame(len, 16'($urandom), $urandom_range(0, 4) == 0);
                fed += len + 5;
            end
        end
    endtask

    // Hold the sender until every byte is taken and every result has come out.
    task automatic wait_idle();
        @(posedge i_clk);
        while (pending_bytes.size() != 0 || i_in_valid)
            @(posedge i_clk);
        while (frames_due.size() != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input logic [7:0] value);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        do
            @(negedge i_clk);
        while (!cfg_fire);
        i_cfg_valid <= 1'b0;
    endtask

    initial begin
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // noise while hunting, empty payload, extremes with a bad check,
        // start byte inside a frame, and a too-long length
        pending_bytes.push_back(8'h00);
        add_frame(8'd0, 16'h0000, 1'b0);
        add_frame(8'd1, 16'hFFFF, 1'b1);
        add_frame(8'd1, {sof_cfg, sof_cfg}, 1'b0);
        pending_bytes.push_back(sof_cfg);
        pending_bytes.push_back(max_len_cfg + 8'd1);
        add_traffic(180);
        wait_idle();

        write_reg(CFG_START_BYTE, 8'h00);
        write_reg(CFG_MAX_PAYLOAD, 8'h00);
        @(posedge i_clk);
        add_traffic(70);
        wait_idle();

        write_reg(CFG_START_BYTE, 8'hFF);
        write_reg(CFG_MAX_PAYLOAD, 8'hFF);
        @(posedge i_clk);
        add_frame(8'hFF, 16'($urandom), 1'b0);
        add_traffic(60);
        wait_idle();

        write_reg(CFG_START_BYTE, 8'($urandom));
        write_reg(CFG_MAX_PAYLOAD, 8'($urandom_range(1, 40)));
        @(posedge i_clk);
        add_traffic(220);
        // stall the output while bytes keep coming, so the input backs up
        @(negedge i_clk);
        stall_requests++;
        wait_idle();

        write_reg(CFG_START_BYTE, START_BYTE_RST);
        write_reg(CFG_MAX_PAYLOAD, 8'($urandom_range(8, 250)));
        @(negedge i_clk);
        quiet_tail <= 1'b1;
        @(posedge i_clk);
        add_traffic(80);
        wait_idle();

        fault_count += frames_due.size();
        if (fault_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
